// ===== hw/rtl/cmdpwm_pkg.sv =====
// Shared types, codes and reset values of the command-driven motor PWM block.
package cmdpwm_pkg;

    localparam int PERIOD_W = 16;
    localparam int DUTY_W   = 8;
    localparam int SERVO_W  = 14;
    localparam int STEP_W   = 8;
    localparam int PINS_W   = 6;
    localparam int DIR_W    = 4;
    localparam int RESP_W   = 4;
    localparam int CMD_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DATA_W = 32;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TOP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_DUTY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVO_STEP = 3'd4;

    // Reset values
    localparam logic [PERIOD_W-1:0] PERIOD_TOP_RST = 16'd300;
    localparam logic [DUTY_W-1:0]   RUN_DUTY_RST   = 8'd50;
    localparam logic [SERVO_W-1:0]  SERVO_MIN_RST  = 14'd130;
    localparam logic [SERVO_W-1:0]  SERVO_MAX_RST  = 14'd270;
    localparam logic [STEP_W-1:0]   SERVO_STEP_RST = 8'd10;
    localparam logic [SERVO_W-1:0]  SERVO_POS_RST  = 14'd150;

    // Item kinds carried in tuser
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_COMMAND = 1'b1;

    // Command characters
    localparam logic [CMD_W-1:0] CMD_LIFT_UP    = 8'h77; // 'w'
    localparam logic [CMD_W-1:0] CMD_LIFT_DOWN  = 8'h65; // 'e'
    localparam logic [CMD_W-1:0] CMD_ELBOW_UP   = 8'h61; // 'a'
    localparam logic [CMD_W-1:0] CMD_ELBOW_DOWN = 8'h73; // 's'
    localparam logic [CMD_W-1:0] CMD_BASE_LEFT  = 8'h7A; // 'z'
    localparam logic [CMD_W-1:0] CMD_BASE_RIGHT = 8'h78; // 'x'
    localparam logic [CMD_W-1:0] CMD_STOP_LIFT  = 8'h6A; // 'j'
    localparam logic [CMD_W-1:0] CMD_STOP_BASE  = 8'h68; // 'h'
    localparam logic [CMD_W-1:0] CMD_STOP_ELBOW = 8'h67; // 'g'
    localparam logic [CMD_W-1:0] CMD_SERVO_OPEN = 8'h6C; // 'l'
    localparam logic [CMD_W-1:0] CMD_SERVO_CLOSE = 8'h70; // 'p'

    typedef enum logic [RESP_W-1:0] {
        RESP_NONE  = 4'd0,
        RESP_UP1   = 4'd1,
        RESP_DOWN1 = 4'd2,
        RESP_UP2   = 4'd3,
        RESP_DOWN2 = 4'd4,
        RESP_LEFT  = 4'd5,
        RESP_RIGHT = 4'd6,
        RESP_STOP  = 4'd7,
        RESP_OPEN  = 4'd8,
        RESP_CLOSE = 4'd9
    } resp_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] period_top;
        logic [DUTY_W-1:0]   run_duty;
        logic [SERVO_W-1:0]  servo_min;
        logic [SERVO_W-1:0]  servo_max;
        logic [STEP_W-1:0]   servo_step;
    } cfg_t;

    typedef struct packed {
        logic [PINS_W-1:0]  pwm_pins;
        logic [DIR_W-1:0]   direction_bits;
        logic [SERVO_W-1:0] servo_position;
        resp_t              response;
    } result_t;

endpackage

// ===== hw/rtl/cmdpwm_cfg.sv =====
// Configuration register file of the command-driven motor PWM block.
module cmdpwm_cfg
    import cmdpwm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_top <= PERIOD_TOP_RST;
            cfg_reg.run_duty   <= RUN_DUTY_RST;
            cfg_reg.servo_min  <= SERVO_MIN_RST;
            cfg_reg.servo_max  <= SERVO_MAX_RST;
            cfg_reg.servo_step <= SERVO_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PERIOD_TOP: cfg_reg.period_top <= cfg_data[PERIOD_W-1:0];
                CFG_RUN_DUTY:   cfg_reg.run_duty   <= cfg_data[DUTY_W-1:0];
                CFG_SERVO_MIN:  cfg_reg.servo_min  <= cfg_data[SERVO_W-1:0];
                CFG_SERVO_MAX:  cfg_reg.servo_max  <= cfg_data[SERVO_W-1:0];
                CFG_SERVO_STEP: cfg_reg.servo_step <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/cmdpwm_core.sv =====
// Motor state, PWM counter and command decode; one item per enabled cycle.
module cmdpwm_core
    import cmdpwm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_en,
    input  logic             kind,
    input  logic [CMD_W-1:0] command_byte,
    input  cfg_t             cfg,
    output result_t          result
);

    logic [PERIOD_W-1:0] counter_reg, counter_next;
    logic [DUTY_W-1:0]   lift_reg, lift_next;
    logic [DUTY_W-1:0]   elbow_reg, elbow_next;
    logic [DUTY_W-1:0]   base_reg, base_next;
    logic [DIR_W-1:0]    dir_reg, dir_next;
    logic [SERVO_W-1:0]  servo_reg, servo_next;
    logic [PINS_W-1:0]   pin_reg, pin_next;
    resp_t               resp;

    logic [PERIOD_W-1:0] cnt_inc;
    logic [SERVO_W:0]    servo_up;
    logic [SERVO_W:0]    servo_dn;

    assign cnt_inc  = counter_reg + PERIOD_W'(1);
    assign servo_up = {1'b0, servo_reg} + {{(SERVO_W+1-STEP_W){1'b0}}, cfg.servo_step};
    assign servo_dn = {1'b0, servo_reg} - {{(SERVO_W+1-STEP_W){1'b0}}, cfg.servo_step};

    always_comb
    begin
        counter_next = counter_reg;
        lift_next    = lift_reg;
        elbow_next   = elbow_reg;
        base_next    = base_reg;
        dir_next     = dir_reg;
        servo_next   = servo_reg;
        pin_next     = pin_reg;
        resp         = RESP_NONE;
        if (kind == KIND_TICK)
        begin
            // Latch pins against the counter before it advances
            pin_next[0] = 1'b1;
            pin_next[1] = 1'b1;
            pin_next[2] = counter_reg >= {{(PERIOD_W-DUTY_W){1'b0}}, base_reg};
            pin_next[3] = counter_reg >= {{(PERIOD_W-DUTY_W){1'b0}}, elbow_reg};
            pin_next[4] = counter_reg >= {{(PERIOD_W-DUTY_W){1'b0}}, lift_reg};
            pin_next[5] = pin_next[4];
            counter_next = (cnt_inc > cfg.period_top) ? '0 : cnt_inc;
        end
        else
        begin
            case (command_byte)
                CMD_LIFT_UP:
                begin
                    lift_next   = cfg.run_duty;
                    dir_next[0] = 1'b0;
                    dir_next[3] = 1'b1;
                    resp        = RESP_UP1;
                end
                CMD_LIFT_DOWN:
                begin
                    lift_next   = cfg.run_duty;
                    dir_next[0] = 1'b1;
                    dir_next[3] = 1'b0;
                    resp        = RESP_DOWN1;
                end
                CMD_ELBOW_UP:
                begin
                    elbow_next  = cfg.run_duty;
                    dir_next[1] = 1'b0;
                    resp        = RESP_UP2;
                end
                CMD_ELBOW_DOWN:
                begin
                    elbow_next  = cfg.run_duty;
                    dir_next[1] = 1'b1;
                    resp        = RESP_DOWN2;
                end
                CMD_BASE_LEFT:
                begin
                    base_next   = cfg.run_duty;
                    dir_next[2] = 1'b0;
                    resp        = RESP_LEFT;
                end
                CMD_BASE_RIGHT:
                begin
                    base_next   = cfg.run_duty;
                    dir_next[2] = 1'b1;
                    resp        = RESP_RIGHT;
                end
                CMD_STOP_LIFT:
                begin
                    lift_next = '0;
                    resp      = RESP_STOP;
                end
                CMD_STOP_BASE:
                begin
                    base_next = '0;
                    resp      = RESP_STOP;
                end
                CMD_STOP_ELBOW:
                begin
                    elbow_next = '0;
                    resp       = RESP_STOP;
                end
                CMD_SERVO_OPEN:
                begin
                    // Clamp at the top; the sum is kept one bit wider
                    servo_next = (servo_up >= {1'b0, cfg.servo_max}) ?
                                 cfg.servo_max : servo_up[SERVO_W-1:0];
                    resp       = RESP_OPEN;
                end
                CMD_SERVO_CLOSE:
                begin
                    // A borrow means the difference went negative
                    servo_next = (servo_dn[SERVO_W] ||
                                  servo_dn[SERVO_W-1:0] <= cfg.servo_min) ?
                                 cfg.servo_min : servo_dn[SERVO_W-1:0];
                    resp       = RESP_CLOSE;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            lift_reg    <= '0;
            elbow_reg   <= '0;
            base_reg    <= '0;
            dir_reg     <= '0;
            servo_reg   <= SERVO_POS_RST;
            pin_reg     <= '0;
        end
        else if (item_en)
        begin
            counter_reg <= counter_next;
            lift_reg    <= lift_next;
            elbow_reg   <= elbow_next;
            base_reg    <= base_next;
            dir_reg     <= dir_next;
            servo_reg   <= servo_next;
            pin_reg     <= pin_next;
        end
    end

    assign result.pwm_pins       = pin_next;
    assign result.direction_bits = dir_next;
    assign result.servo_position = servo_next;
    assign result.response       = resp;

endmodule

// ===== hw/rtl/command_driven_motor_pwm.sv =====
// Top level of the command-driven motor PWM block: input and result registers.
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata command_byte, tuser kind
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata pins, dir, servo, response
//  cfg       in         cfg_we                        cfg_index, cfg_data
//
// An accepted item passes through the input register, then the decode and state
// update into the result register. One beat per cycle is sustained while m_axis
// is not stalled; state registers update in the same cycle the result is loaded.
// Reset clears both valid flags and sets configuration and core state to defaults,
// not the data registers. A stalled m_axis holds the result and backs up into s_axis_tready.
module command_driven_motor_pwm
    import cmdpwm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [CMD_W-1:0]      s_axis_tdata,  // [7:0] command_byte
    input  logic                  s_axis_tuser,  // [0] kind
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [5:0] pwm_pins, [9:6] direction_bits, [23:10] servo_position,
    // [27:24] response, [31:28] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    result_t result;

    logic             in_valid_reg;
    logic             in_kind_reg;
    logic [CMD_W-1:0] in_cmd_reg;
    logic             out_valid_reg;
    result_t          out_reg;
    logic             advance;
    logic             s_fire;

    // Move the held beat into the result register when that register frees up
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    cmdpwm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cmdpwm_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_en      (advance),
        .kind         (in_kind_reg),
        .command_byte (in_cmd_reg),
        .cfg          (cfg),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_kind_reg <= s_axis_tuser;
            in_cmd_reg  <= s_axis_tdata;
        end
        if (advance)
            out_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W-PINS_W-DIR_W-SERVO_W-RESP_W){1'b0}},
                            out_reg.response, out_reg.servo_position,
                            out_reg.direction_bits, out_reg.pwm_pins};

`ifndef ASSERT_OFF
    a_tick_no_response: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_kind_reg == KIND_TICK) |=> out_reg.response == RESP_NONE)
        else $error("tick beat produced a command response");

    a_tick_pins_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_kind_reg == KIND_TICK) |=> out_reg.pwm_pins[1:0] == 2'b11)
        else $error("channels one and two not high after a tick");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stalled with an empty input register");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("advanced beat did not reach the output");
`endif

endmodule
